// File: rtl/cbam_pkg.sv
// ---------------------------------------------------------------------------
// cbam_pkg
// Types and constants shared by the cartridge bank address mapper modules.
// ---------------------------------------------------------------------------
package cbam_pkg;

  // request codes
  localparam logic [1:0] REQ_CPU_WRITE = 2'd0;
  localparam logic [1:0] REQ_CPU_READ  = 2'd1;
  localparam logic [1:0] REQ_PPU_READ  = 2'd2;
  localparam logic [1:0] REQ_PPU_WRITE = 2'd3;

  // mirroring codes
  localparam logic [1:0] MIR_HORIZ    = 2'd0;
  localparam logic [1:0] MIR_VERT     = 2'd1;
  localparam logic [1:0] MIR_ONE_LOW  = 2'd2;
  localparam logic [1:0] MIR_ONE_HIGH = 2'd3;

  // CPU register pages (address bits 15:12 after masking with F003)
  localparam logic [3:0] PAGE_PRG16 = 4'h8;
  localparam logic [3:0] PAGE_CTRL  = 4'hB;
  localparam logic [3:0] PAGE_PRG8  = 4'hC;
  localparam logic [3:0] PAGE_CHR_LO = 4'hD;
  localparam logic [3:0] PAGE_CHR_HI = 4'hE;
  localparam logic [1:0] CTRL_LOW_BITS = 2'd3;

  localparam logic [7:0] CTRL_RESET = 8'h20;
  localparam logic [7:0] CTRL_NT_MASK = 8'h2F;

  // nametable layout codes (control byte masked with 2F)
  localparam logic [7:0] NT_VERT_A  = 8'h20;
  localparam logic [7:0] NT_VERT_B  = 8'h27;
  localparam logic [7:0] NT_HORIZ_A = 8'h23;
  localparam logic [7:0] NT_HORIZ_B = 8'h24;
  localparam logic [7:0] NT_LOW_A   = 8'h28;
  localparam logic [7:0] NT_LOW_B   = 8'h2F;
  localparam logic [7:0] NT_HIGH_A  = 8'h2B;
  localparam logic [7:0] NT_HIGH_B  = 8'h2C;

  // config register indexes
  localparam logic CFG_PRG_BANKS = 1'b0;
  localparam logic CFG_CHR_BANKS = 1'b1;

  localparam int REM_W = 11;  // widest divisor: 255 * 8

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_t;

  typedef struct packed {
    logic        mapped;
    logic [21:0] mapped_address;
    logic        ciram_page;
    logic [1:0]  mirror_mode;
  } out_t;

  typedef struct packed {
    logic        en;
    logic [15:0] address;
    logic [7:0]  data;
  } reg_wr_t;

  typedef struct packed {
    logic [3:0]      prg16_sel;
    logic [4:0]      prg8_sel;
    logic [7:0][7:0] chr_bank;
    logic [7:0]      control;
    logic [1:0]      mirror;
    logic [3:0]      ciram_map;
    logic [3:0][7:0] nt_bank;
  } bank_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_REFRESH,
    S_DIV,
    S_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    K_PRG16,
    K_PRG8,
    K_CHR
  } addr_kind_t;

endpackage

// File: rtl/cbam_rem_unit.sv
// ---------------------------------------------------------------------------
// cbam_rem_unit
// Restoring remainder unit: 8-bit dividend modulo an 11-bit divisor, one
// quotient bit per cycle.
// ---------------------------------------------------------------------------
module cbam_rem_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [7:0]               dividend,
  input  logic [cbam_pkg::REM_W-1:0] divisor,
  output logic                     done,
  output logic [cbam_pkg::REM_W-1:0] remainder
);

  logic                       busy;
  logic [2:0]                 cnt;
  logic [7:0]                 dvd;
  logic [cbam_pkg::REM_W-1:0] dsr;
  logic [cbam_pkg::REM_W:0]   trial;
  logic [cbam_pkg::REM_W:0]   diff;

  always_comb begin
    trial = {remainder, dvd[7]};
    diff  = trial - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      dvd       <= dividend;
      dsr       <= divisor;
    end else if (busy) begin
      dvd <= {dvd[6:0], 1'b0};
      // remainder stays below the divisor, so the top trial bit drops out
      if (!diff[cbam_pkg::REM_W]) remainder <= diff[cbam_pkg::REM_W-1:0];
      else                        remainder <= trial[cbam_pkg::REM_W-1:0];
    end
  end

endmodule

// File: rtl/cbam_bank_regs.sv
// ---------------------------------------------------------------------------
// cbam_bank_regs
// Banking registers written by CPU beats, plus the nametable tables that are
// recomputed the cycle after a control or character bank write.
// ---------------------------------------------------------------------------
module cbam_bank_regs (
  input  logic                  clk,
  input  logic                  rst,
  input  cbam_pkg::reg_wr_t     wr,
  output cbam_pkg::bank_state_t st
);

  logic [3:0]      prg16_sel;
  logic [4:0]      prg8_sel;
  logic [7:0][7:0] chr_bank;
  logic [7:0]      control;
  logic [1:0]      mirror;
  logic [3:0]      ciram_map;
  logic [3:0][7:0] nt_bank;

  logic            refresh;
  logic [7:0]      cb;
  logic [7:0]      b4, b5, b6, b7;
  logic [7:0]      e6, e7, o6, o7;
  logic [3:0][7:0] nt_gen;
  logic [3:0][7:0] nt_special;
  logic [3:0]      ciram_special;
  logic [1:0]      mirror_special;
  logic            special;
  logic [3:0]      ciram_next;
  logic [1:0]      mirror_next;
  logic [3:0][7:0] nt_next;
  logic [3:0]      page;
  logic            hit_chr;

  always_comb begin
    page    = wr.address[15:12];
    hit_chr = (page == cbam_pkg::PAGE_CHR_LO) || (page == cbam_pkg::PAGE_CHR_HI);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg16_sel <= '0;
      prg8_sel  <= '0;
      for (int i = 0; i < 8; i++) chr_bank[i] <= 8'(i);
      control   <= cbam_pkg::CTRL_RESET;
      refresh   <= 1'b0;
    end else begin
      refresh <= 1'b0;
      if (wr.en) begin
        if (page == cbam_pkg::PAGE_PRG16) begin
          prg16_sel <= wr.data[3:0];
        end else if (page == cbam_pkg::PAGE_CTRL &&
                     wr.address[1:0] == cbam_pkg::CTRL_LOW_BITS) begin
          control <= wr.data;
          refresh <= 1'b1;
        end else if (page == cbam_pkg::PAGE_PRG8) begin
          prg8_sel <= wr.data[4:0];
        end else if (hit_chr) begin
          chr_bank[{page == cbam_pkg::PAGE_CHR_HI, wr.address[1:0]}] <= wr.data;
          refresh <= 1'b1;
        end
      end
    end
  end

  // table recompute from the settled registers
  always_comb begin
    cb = control;
    b4 = chr_bank[4];
    b5 = chr_bank[5];
    b6 = chr_bank[6];
    b7 = chr_bank[7];
    e6 = {b6[7:1], 1'b0};
    e7 = {b7[7:1], 1'b0};
    o6 = {b6[7:1], 1'b1};
    o7 = {b7[7:1], 1'b1};

    special        = 1'b1;
    nt_special     = {o7, e7, o6, e6};
    ciram_special  = 4'b1010;
    mirror_special = cbam_pkg::MIR_VERT;
    case (cb & cbam_pkg::CTRL_NT_MASK) inside
      cbam_pkg::NT_VERT_A, cbam_pkg::NT_VERT_B: begin
        nt_special     = {o7, e7, o6, e6};
        ciram_special  = 4'b1010;
        mirror_special = cbam_pkg::MIR_VERT;
      end
      cbam_pkg::NT_HORIZ_A, cbam_pkg::NT_HORIZ_B: begin
        nt_special     = {o7, o6, e7, e6};
        ciram_special  = 4'b1100;
        mirror_special = cbam_pkg::MIR_HORIZ;
      end
      cbam_pkg::NT_LOW_A, cbam_pkg::NT_LOW_B: begin
        nt_special     = {e7, e7, e6, e6};
        ciram_special  = 4'b0000;
        mirror_special = cbam_pkg::MIR_ONE_LOW;
      end
      cbam_pkg::NT_HIGH_A, cbam_pkg::NT_HIGH_B: begin
        nt_special     = {o7, o6, o7, o6};
        ciram_special  = 4'b1111;
        mirror_special = cbam_pkg::MIR_ONE_HIGH;
      end
      default: special = 1'b0;
    endcase

    case (cb[2:0])
      3'd1, 3'd5:       nt_gen = {b7, b6, b5, b4};
      3'd2, 3'd3, 3'd4: nt_gen = {b7, b6, b7, b6};
      default:          nt_gen = {b7, b7, b6, b6};
    endcase

    if (special) begin
      nt_next     = nt_special;
      ciram_next  = ciram_special;
      mirror_next = mirror_special;
    end else begin
      nt_next    = nt_gen;
      ciram_next = {nt_gen[3][0], nt_gen[2][0], nt_gen[1][0], nt_gen[0][0]};
      if (cb[2:0] == 3'd0 || cb[2:0] >= 3'd6) begin
        if (!b6[0] && b7[0]) mirror_next = cbam_pkg::MIR_VERT;
        else mirror_next = b6[0] ? cbam_pkg::MIR_ONE_HIGH : cbam_pkg::MIR_ONE_LOW;
      end else begin
        mirror_next = cbam_pkg::MIR_VERT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mirror    <= cbam_pkg::MIR_VERT;
      ciram_map <= 4'b1010;
    end else if (refresh && !cb[4]) begin
      mirror    <= mirror_next;
      ciram_map <= ciram_next;
    end
  end

  // undefined until written; only read while control bit 4 is set
  always_ff @(posedge clk) begin
    if (refresh && cb[4]) nt_bank <= nt_next;
  end

  always_comb begin
    st.prg16_sel = prg16_sel;
    st.prg8_sel  = prg8_sel;
    st.chr_bank  = chr_bank;
    st.control   = control;
    st.mirror    = mirror;
    st.ciram_map = ciram_map;
    st.nt_bank   = nt_bank;
  end

endmodule

// File: rtl/cartridge_bank_address_mapper_core.sv
// ---------------------------------------------------------------------------
// cartridge_bank_address_mapper_core
// Maps CPU and PPU bus beats to program/character memory offsets.
// Fixed-bank, CIRAM and unmapped beats go from S_DECODE straight to S_DONE;
// register writes pass S_REFRESH, banked beats wait in S_DIV on the shared
// remainder unit. One beat in flight: S_DONE holds while the output stalls,
// and the next beat is accepted in S_IDLE. Synchronous reset restores all
// banking registers but nametable banks; config resets to 8 PRG banks, CHR RAM.
// ---------------------------------------------------------------------------
module cartridge_bank_address_mapper_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  cbam_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output cbam_pkg::out_t  out_data,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  cbam_pkg::seq_state_t  state, state_next;
  cbam_pkg::in_t         item;
  cbam_pkg::bank_state_t bank;
  cbam_pkg::reg_wr_t     wr;
  cbam_pkg::addr_kind_t  kind, kind_d;

  logic [7:0]  prg_banks_16k;
  logic [7:0]  chr_banks_8k;

  logic        res_mapped, res_page;
  logic [21:0] res_addr;
  logic [13:0] offset;

  // decode outputs
  logic                       d_mapped, d_page, d_need_mod;
  logic [21:0]                d_addr;
  logic [13:0]                d_offset;
  logic [7:0]                 d_dividend;
  logic [cbam_pkg::REM_W-1:0] d_divisor;
  logic [cbam_pkg::REM_W-1:0] chr1k;
  logic [8:0]                 n8;
  logic [8:0]                 last8;
  logic [13:0]                ppu_a;
  logic                       ppu_ok;
  logic [2:0]                 slot;
  logic [2:0]                 pat_reg;
  logic                       two_k;
  logic [7:0]                 pat_bank;

  logic                       rem_start, rem_done;
  logic [cbam_pkg::REM_W-1:0] rem;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_banks_16k <= 8'd8;
      chr_banks_8k  <= 8'd0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == cbam_pkg::CFG_PRG_BANKS) prg_banks_16k <= pwdata[7:0];
      else                                     chr_banks_8k  <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == cbam_pkg::CFG_PRG_BANKS) prdata[7:0] = prg_banks_16k;
    else                                     prdata[7:0] = chr_banks_8k;
  end

  cbam_bank_regs u_regs (
    .clk (clk),
    .rst (rst),
    .wr  (wr),
    .st  (bank)
  );

  cbam_rem_unit u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (d_dividend),
    .divisor   (d_divisor),
    .done      (rem_done),
    .remainder (rem)
  );

  // beat decode
  always_comb begin
    n8     = {prg_banks_16k, 1'b0};
    last8  = n8 - 9'd1;
    chr1k  = (chr_banks_8k == 8'd0) ? cbam_pkg::REM_W'(8) : {chr_banks_8k, 3'b000};
    ppu_a  = item.address[13:0];
    ppu_ok = (item.req_type == cbam_pkg::REQ_PPU_READ) || (chr_banks_8k == 8'd0);

    slot = ppu_a[12:10];
    case (bank.control[1:0])
      2'd0: begin
        pat_reg = slot;
        two_k   = 1'b0;
      end
      2'd1: begin
        pat_reg = {1'b0, slot[2:1]};
        two_k   = 1'b1;
      end
      default: begin
        pat_reg = slot[2] ? {2'b10, slot[1]} : slot;
        two_k   = slot[2];
      end
    endcase
    pat_bank = bank.chr_bank[pat_reg];
    if (two_k && bank.control[5]) pat_bank = {pat_bank[7:1], slot[0]};

    d_mapped   = 1'b0;
    d_page     = 1'b0;
    d_need_mod = 1'b0;
    d_addr     = '0;
    d_offset   = '0;
    d_dividend = '0;
    d_divisor  = chr1k;
    kind_d     = cbam_pkg::K_CHR;

    case (item.req_type)
      cbam_pkg::REQ_CPU_WRITE: ;
      cbam_pkg::REQ_CPU_READ: begin
        if (prg_banks_16k != 8'd0 && item.address[15]) begin
          d_mapped = 1'b1;
          if (!item.address[14]) begin
            d_need_mod = 1'b1;
            kind_d     = cbam_pkg::K_PRG16;
            d_dividend = {4'b0, bank.prg16_sel};
            d_divisor  = cbam_pkg::REM_W'(prg_banks_16k);
            d_offset   = item.address[13:0];
          end else if (!item.address[13]) begin
            d_need_mod = 1'b1;
            kind_d     = cbam_pkg::K_PRG8;
            d_dividend = {3'b0, bank.prg8_sel};
            d_divisor  = cbam_pkg::REM_W'(n8);
            d_offset   = {1'b0, item.address[12:0]};
          end else begin
            d_addr = {last8, item.address[12:0]};
          end
        end
      end
      default: begin
        d_offset = {4'b0, ppu_a[9:0]};
        if (!ppu_a[13]) begin
          if (ppu_ok) begin
            d_mapped   = 1'b1;
            d_need_mod = 1'b1;
            d_dividend = pat_bank;
          end
        end else if (ppu_a[13:8] != 6'h3F) begin
          if (bank.control[4]) begin
            if (ppu_ok) begin
              d_mapped   = 1'b1;
              d_need_mod = 1'b1;
              d_dividend = bank.nt_bank[ppu_a[11:10]];
            end
          end else begin
            d_page = bank.ciram_map[ppu_a[11:10]];
          end
        end
      end
    endcase
  end

  // sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      cbam_pkg::S_IDLE:    if (in_valid) state_next = cbam_pkg::S_DECODE;
      cbam_pkg::S_DECODE: begin
        if (item.req_type == cbam_pkg::REQ_CPU_WRITE) state_next = cbam_pkg::S_REFRESH;
        else if (d_need_mod)                          state_next = cbam_pkg::S_DIV;
        else                                          state_next = cbam_pkg::S_DONE;
      end
      cbam_pkg::S_REFRESH: state_next = cbam_pkg::S_DONE;
      cbam_pkg::S_DIV:     if (rem_done) state_next = cbam_pkg::S_DONE;
      cbam_pkg::S_DONE:    if (!out_stall) state_next = cbam_pkg::S_IDLE;
      default:             state_next = cbam_pkg::S_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    rem_start  = 1'b0;
    wr.en      = 1'b0;
    wr.address = item.address;
    wr.data    = item.write_data;
    unique case (state)
      cbam_pkg::S_IDLE:   in_stall = 1'b0;
      cbam_pkg::S_DECODE: begin
        wr.en     = (item.req_type == cbam_pkg::REQ_CPU_WRITE);
        rem_start = d_need_mod;
      end
      cbam_pkg::S_DONE:   out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= cbam_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == cbam_pkg::S_IDLE && in_valid) item <= in_data;
    if (state == cbam_pkg::S_DECODE) begin
      res_mapped <= d_mapped;
      res_page   <= d_page;
      res_addr   <= d_addr;
      offset     <= d_offset;
      kind       <= kind_d;
    end else if (state == cbam_pkg::S_DIV && rem_done) begin
      case (kind)
        cbam_pkg::K_PRG16: res_addr <= {rem[7:0], offset};
        cbam_pkg::K_PRG8:  res_addr <= {rem[8:0], offset[12:0]};
        default:           res_addr <= {1'b0, rem, offset[9:0]};
      endcase
    end
  end

  always_comb begin
    out_data.mapped         = res_mapped;
    out_data.mapped_address = res_addr;
    out_data.ciram_page     = res_page;
    out_data.mirror_mode    = bank.mirror;
  end

endmodule
